// ===== rtl/core/text_console_writer_top_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the text console writer
// ---------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_WRITER_TOP_ASSERT_SVH
`define TEXT_CONSOLE_WRITER_TOP_ASSERT_SVH

// same-cycle implication, masked during reset
`define TCW_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tcw check failed");

// next-cycle implication, masked during reset
`define TCW_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tcw check failed");

// next-cycle implication, always active
`define TCW_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("tcw check failed");

`endif

// ===== rtl/core/tcw_pkg.sv =====
// ---------------------------------------------------------------------------
// tcw_pkg
// Shared types and constants of the text console writer.
// ---------------------------------------------------------------------------
`default_nettype none

package tcw_pkg;

  localparam int COLUMNS    = 80;
  localparam int ROWS_COUNT = 25;
  localparam int CELL_TOTAL = COLUMNS * ROWS_COUNT;

  localparam int ADDR_W = $clog2(CELL_TOTAL);
  localparam int COL_W  = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
  localparam int ROW_W  = (ROWS_COUNT > 1) ? $clog2(ROWS_COUNT) : 1;

  // fixed field widths
  localparam int CURSOR_W = 11;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W = 8;

  localparam logic [7:0] NEWLINE_CODE = 8'd10;

  localparam logic [1:0] MODE_PUT   = 2'd0;
  localparam logic [1:0] MODE_CLEAR = 2'd1;
  localparam logic [1:0] MODE_READ  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_FILL_COLOR  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FILL_SYMBOL = 1'd1;

  localparam logic [7:0] FILL_COLOR_RST  = 8'd15;
  localparam logic [7:0] FILL_SYMBOL_RST = 8'd32;

  // first cell of the bottom row
  localparam logic [ADDR_W-1:0] SCROLL_BASE = ADDR_W'(CELL_TOTAL - COLUMNS);
  localparam logic [ADDR_W-1:0] COPY_LAST   = ADDR_W'(CELL_TOTAL - COLUMNS - 1);
  localparam logic [ADDR_W-1:0] CELL_LAST   = ADDR_W'(CELL_TOTAL - 1);

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] symbol;
    logic [7:0] color;
    logic       use_position;
    logic [6:0] col;
    logic [4:0] row;
  } cmd_t;

  typedef struct packed {
    logic [CURSOR_W-1:0] cursor_pos;
    logic [7:0]          cell_symbol;
    logic [7:0]          cell_color;
    logic                scrolled;
  } res_t;

  typedef struct packed {
    logic [7:0] color;
    logic [7:0] symbol;
  } cell_t;

  typedef struct packed {
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    cell_t             wr_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
  } ram_req_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_COPY,
    ST_FILL
  } state_t;

endpackage

`default_nettype wire

// ===== rtl/core/tcw_cell_ram.sv =====
// ---------------------------------------------------------------------------
// tcw_cell_ram
// Screen cell store: one write port, one read port, registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module tcw_cell_ram (
  input  logic              clk,
  input  tcw_pkg::ram_req_t req,
  output tcw_pkg::cell_t    rd_data
);

  tcw_pkg::cell_t mem [tcw_pkg::CELL_TOTAL];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data <= mem[req.rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/tcw_ctrl.sv =====
// ---------------------------------------------------------------------------
// tcw_ctrl
// Command sequencer: cursor, fill registers, put/read/clear and the
// scroll copy sweep over the cell store.
// ---------------------------------------------------------------------------
`default_nettype none

module tcw_ctrl (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  tcw_pkg::cmd_t                       cmd,
  output logic                                done,
  output tcw_pkg::res_t                       result,
  input  logic                                cfg_we,
  input  logic [tcw_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [tcw_pkg::CFG_W-1:0]           cfg_data,
  output tcw_pkg::ram_req_t                   ram_req,
  input  tcw_pkg::cell_t                      ram_rd_data
);

  tcw_pkg::state_t state, state_next;

  logic [tcw_pkg::ADDR_W-1:0] cnt;
  logic [tcw_pkg::ADDR_W-1:0] cursor;
  logic [tcw_pkg::COL_W-1:0]  cur_col;
  logic [tcw_pkg::ROW_W-1:0]  cur_row;
  logic [7:0]                 fill_color;
  logic [7:0]                 fill_symbol;

  // latched item
  logic [1:0]                 it_mode;
  logic [7:0]                 it_symbol;
  logic [7:0]                 it_color;
  logic                       it_pos_ok;
  logic [tcw_pkg::ADDR_W-1:0] it_pos_off;
  logic [tcw_pkg::COL_W-1:0]  it_col;
  logic [tcw_pkg::ROW_W-1:0]  it_row;

  logic                       scrolled;
  logic                       rd_flag;
  logic                       cp_pend;
  logic [tcw_pkg::ADDR_W-1:0] cp_addr;

  logic                       accept;
  logic                       pos_ok;
  logic [tcw_pkg::COL_W-1:0]  e_col;
  logic [tcw_pkg::ROW_W-1:0]  e_row;
  logic [tcw_pkg::ADDR_W-1:0] off;
  logic                       is_nl;
  logic [tcw_pkg::COL_W:0]    col_inc;
  logic [tcw_pkg::ROW_W:0]    row_inc;
  logic                       wrap;
  logic                       need_scroll;
  logic [tcw_pkg::ADDR_W-1:0] lin_next;

  assign busy   = (state != tcw_pkg::ST_IDLE);
  assign accept = start && !busy;

  assign pos_ok = cmd.use_position && (int'(cmd.col) < tcw_pkg::COLUMNS)
                  && (int'(cmd.row) < tcw_pkg::ROWS_COUNT);

  // effective target of the latched item
  assign e_col   = it_pos_ok ? it_col : cur_col;
  assign e_row   = it_pos_ok ? it_row : cur_row;
  assign off     = it_pos_ok ? it_pos_off : cursor;
  assign is_nl   = (it_symbol == tcw_pkg::NEWLINE_CODE);
  assign col_inc = {1'b0, e_col} + (tcw_pkg::COL_W+1)'(1);
  assign row_inc = {1'b0, e_row} + (tcw_pkg::ROW_W+1)'(1);
  assign wrap    = is_nl || (col_inc == (tcw_pkg::COL_W+1)'(tcw_pkg::COLUMNS));
  assign need_scroll = wrap && (row_inc == (tcw_pkg::ROW_W+1)'(tcw_pkg::ROWS_COUNT));
  // newline lands on the first cell of the next row
  assign lin_next = is_nl
      ? (off - tcw_pkg::ADDR_W'(e_col) + tcw_pkg::ADDR_W'(tcw_pkg::COLUMNS))
      : (off + tcw_pkg::ADDR_W'(1));

  // next state
  always_comb begin
    state_next = state;
    case (state)
      tcw_pkg::ST_IDLE: begin
        if (accept) state_next = tcw_pkg::ST_EXEC;
      end
      tcw_pkg::ST_EXEC: begin
        if (it_mode == tcw_pkg::MODE_PUT && need_scroll) begin
          state_next = tcw_pkg::ST_COPY;
        end else if (it_mode == tcw_pkg::MODE_CLEAR) begin
          state_next = tcw_pkg::ST_FILL;
        end else begin
          state_next = tcw_pkg::ST_IDLE;
        end
      end
      tcw_pkg::ST_COPY: begin
        if (cnt == tcw_pkg::COPY_LAST) state_next = tcw_pkg::ST_FILL;
      end
      tcw_pkg::ST_FILL: begin
        if (!cp_pend && cnt == tcw_pkg::CELL_LAST) state_next = tcw_pkg::ST_IDLE;
      end
      default: state_next = tcw_pkg::ST_IDLE;
    endcase
  end

  // memory port drive
  always_comb begin
    ram_req = '0;
    case (state)
      tcw_pkg::ST_EXEC: begin
        ram_req.wr_en   = (it_mode == tcw_pkg::MODE_PUT) && !is_nl;
        ram_req.wr_addr = off;
        ram_req.wr_data = '{color: it_color, symbol: it_symbol};
        ram_req.rd_en   = (it_mode == tcw_pkg::MODE_READ);
        ram_req.rd_addr = off;
      end
      tcw_pkg::ST_COPY: begin
        ram_req.rd_en   = 1'b1;
        ram_req.rd_addr = cnt + tcw_pkg::ADDR_W'(tcw_pkg::COLUMNS);
        ram_req.wr_en   = cp_pend;
        ram_req.wr_addr = cp_addr;
        ram_req.wr_data = ram_rd_data;
      end
      tcw_pkg::ST_FILL: begin
        // drain the last copied cell before blanking
        ram_req.wr_en   = 1'b1;
        ram_req.wr_addr = cp_pend ? cp_addr : cnt;
        ram_req.wr_data = cp_pend ? ram_rd_data
                                  : tcw_pkg::cell_t'{color: fill_color,
                                                     symbol: fill_symbol};
      end
      default: ram_req = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= tcw_pkg::ST_IDLE;
      cursor      <= '0;
      cur_col     <= '0;
      cur_row     <= '0;
      fill_color  <= tcw_pkg::FILL_COLOR_RST;
      fill_symbol <= tcw_pkg::FILL_SYMBOL_RST;
      done        <= 1'b0;
      scrolled    <= 1'b0;
      rd_flag     <= 1'b0;
      cp_pend     <= 1'b0;
      cnt         <= '0;
    end else begin
      state <= state_next;
      done  <= 1'b0;

      if (cfg_we) begin
        case (cfg_index)
          tcw_pkg::CFG_FILL_COLOR:  fill_color  <= cfg_data;
          tcw_pkg::CFG_FILL_SYMBOL: fill_symbol <= cfg_data;
          default: ;
        endcase
      end

      case (state)
        tcw_pkg::ST_EXEC: begin
          cnt      <= '0;
          cp_pend  <= 1'b0;
          scrolled <= 1'b0;
          rd_flag  <= (it_mode == tcw_pkg::MODE_READ);
          if (it_mode == tcw_pkg::MODE_PUT) begin
            if (need_scroll) begin
              cursor  <= tcw_pkg::SCROLL_BASE;
              cur_col <= '0;
              cur_row <= tcw_pkg::ROW_W'(tcw_pkg::ROWS_COUNT - 1);
            end else begin
              cursor  <= lin_next;
              cur_col <= wrap ? '0 : col_inc[tcw_pkg::COL_W-1:0];
              cur_row <= wrap ? row_inc[tcw_pkg::ROW_W-1:0] : e_row;
              done    <= 1'b1;
            end
          end else if (it_mode == tcw_pkg::MODE_CLEAR) begin
            cursor  <= '0;
            cur_col <= '0;
            cur_row <= '0;
          end else begin
            done <= 1'b1;
          end
        end
        tcw_pkg::ST_COPY: begin
          cp_pend <= 1'b1;
          cp_addr <= cnt;
          cnt     <= (cnt == tcw_pkg::COPY_LAST) ? tcw_pkg::SCROLL_BASE
                                                 : cnt + tcw_pkg::ADDR_W'(1);
        end
        tcw_pkg::ST_FILL: begin
          if (cp_pend) begin
            cp_pend <= 1'b0;
          end else if (cnt == tcw_pkg::CELL_LAST) begin
            done     <= 1'b1;
            scrolled <= (it_mode == tcw_pkg::MODE_PUT);
            rd_flag  <= 1'b0;
          end else begin
            cnt <= cnt + tcw_pkg::ADDR_W'(1);
          end
        end
        default: ;
      endcase
    end
  end

  // item latch; offset product taken on the way in
  always_ff @(posedge clk) begin
    if (accept) begin
      it_mode    <= cmd.mode;
      it_symbol  <= cmd.symbol;
      it_color   <= cmd.color;
      it_pos_ok  <= pos_ok;
      it_col     <= tcw_pkg::COL_W'(cmd.col);
      it_row     <= tcw_pkg::ROW_W'(cmd.row);
      it_pos_off <= tcw_pkg::ADDR_W'(int'(cmd.row) * tcw_pkg::COLUMNS + int'(cmd.col));
    end
  end

  assign result.cursor_pos  = tcw_pkg::CURSOR_W'(cursor);
  assign result.cell_symbol = rd_flag ? ram_rd_data.symbol : 8'd0;
  assign result.cell_color  = rd_flag ? ram_rd_data.color : 8'd0;
  assign result.scrolled    = scrolled;

endmodule

`default_nettype wire

// ===== rtl/core/text_console_writer_top.sv =====
// ---------------------------------------------------------------------------
// text_console_writer_top
// Text-mode console engine: 80x25 cell store with cursor, put, read,
// clear and one-line scroll.
// ---------------------------------------------------------------------------
//  channel | signals                       | transfer when
//  --------+-------------------------------+--------------------------
//  command | start, busy, cmd              | start && !busy
//  result  | done, result                  | done (one cycle, no stall)
//  config  | cfg_we, cfg_index, cfg_data   | cfg_we
//
//  Put, read and unused mode run the execute state and return to idle; the
//  result strobe comes the cycle after the transfer's execute cycle.
//  Clear and scroll sweep the whole store through the single write port of
//  the cell RAM (scroll: copy state, then fill state); busy holds off commands.
//  rst is synchronous and clears cursor, fill registers and control; cell
//  contents stay undefined until the first clear. The receiver cannot stall.
// ---------------------------------------------------------------------------
`default_nettype none

module text_console_writer_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  tcw_pkg::cmd_t                 cmd,
  output logic                          done,
  output tcw_pkg::res_t                 result,
  input  logic                          cfg_we,
  input  logic [tcw_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tcw_pkg::CFG_W-1:0]     cfg_data
);

  tcw_pkg::ram_req_t ram_req;
  tcw_pkg::cell_t    ram_rd_data;

  tcw_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .cmd         (cmd),
    .done        (done),
    .result      (result),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .ram_req     (ram_req),
    .ram_rd_data (ram_rd_data)
  );

  tcw_cell_ram u_ram (
    .clk     (clk),
    .req     (ram_req),
    .rd_data (ram_rd_data)
  );

endmodule

`default_nettype wire

// ===== rtl/core/tcw_checker.sv =====
// ---------------------------------------------------------------------------
// tcw_checker
// Port-level checks of the text console writer, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

`include "text_console_writer_top_assert.svh"

module tcw_checker (
  input logic          clk,
  input logic          rst,
  input logic          start,
  input logic          busy,
  input logic          done,
  input tcw_pkg::res_t result
);

  // result strobe only once the command has retired
  `TCW_ASSERT_IMPL(a_done_idle, clk, rst, done, !busy)

  // a command transfer always occupies the engine next cycle
  `TCW_ASSERT_NEXT(a_accept_busy, clk, rst, start && !busy, busy && !done)

  `TCW_ASSERT_IMPL(a_cursor_range, clk, rst, done, int'(result.cursor_pos) < tcw_pkg::CELL_TOTAL)

  // scroll leaves the cursor at the start of the bottom row
  `TCW_ASSERT_IMPL(a_scroll_cursor, clk, rst, done && result.scrolled, int'(result.cursor_pos) == (tcw_pkg::CELL_TOTAL - tcw_pkg::COLUMNS))

  `TCW_ASSERT_NEXT_ALWAYS(a_reset_quiet, clk, rst, !busy && !done)

endmodule

bind text_console_writer_top tcw_checker u_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .done   (done),
  .result (result)
);

`default_nettype wire

// ===== verif/text_console_writer_top_tb.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// text_console_writer_top_tb
// Self-checking bench for the text console writer. A short table of
// commands (unused mode, clear, put, newline, positions out of range,
// scroll, reads) is followed by three random phases, each with its own
// fill setting and sender idle rate. A shadow screen and cursor predict
// the results that the table does not give, and each result strobe is
// checked against the oldest expected result.
// ---------------------------------------------------------------------------

module text_console_writer_top_tb;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int QUIET_LIMIT      = 20000;
  localparam int RANDOM_PER_PHASE = 184;
  localparam int TAIL_CYCLES      = 8;
  localparam int REPORT_MAX       = 10;

  typedef struct {
    tcw_pkg::cmd_t c;
    bit            known;
    tcw_pkg::res_t want;
  } dir_row_t;

  logic                          clk;
  logic                          rst;
  logic                          start;
  logic                          busy;
  tcw_pkg::cmd_t                 cmd;
  logic                          done;
  tcw_pkg::res_t                 result;
  logic                          cfg_we;
  logic [tcw_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [tcw_pkg::CFG_W-1:0]     cfg_data;

  tcw_pkg::cell_t shadow_cells [tcw_pkg::CELL_TOTAL];
  int             shadow_cursor;
  logic [7:0]     fill_color_q;
  logic [7:0]     fill_symbol_q;
  tcw_pkg::res_t  pending_results [$];
  dir_row_t       dir_table [$];
  int             mismatch_count = 0;
  int             quiet_cycles = 0;
  int             send_idle_pct = 0;

  text_console_writer_top dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .cmd       (cmd),
    .done      (done),
    .result    (result),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Shadow of the console: applies one command, returns its result.
  function automatic tcw_pkg::res_t console_apply(tcw_pkg::cmd_t c);
    tcw_pkg::res_t  r;
    int             off;
    int             i;
    tcw_pkg::cell_t blank;
    r = '0;
    blank.color = fill_color_q;
    blank.symbol = fill_symbol_q;
    off = shadow_cursor;
    if (c.use_position && c.col < tcw_pkg::COLUMNS && c.row < tcw_pkg::ROWS_COUNT)
      off = int'(c.row) * tcw_pkg::COLUMNS + int'(c.col);
    case (c.mode)
      tcw_pkg::MODE_PUT: begin
        if (c.symbol == tcw_pkg::NEWLINE_CODE) begin
          off += tcw_pkg::COLUMNS - (off % tcw_pkg::COLUMNS) - 1;
        end else begin
          shadow_cells[off].color = c.color;
          shadow_cells[off].symbol = c.symbol;
        end
        if (off + 1 >= tcw_pkg::CELL_TOTAL) begin
          // move every row up one, blank the bottom row
          for (i = 0; i < tcw_pkg::CELL_TOTAL - tcw_pkg::COLUMNS; i++)
            shadow_cells[i] = shadow_cells[i + tcw_pkg::COLUMNS];
          for (i = tcw_pkg::CELL_TOTAL - tcw_pkg::COLUMNS; i < tcw_pkg::CELL_TOTAL; i++)
            shadow_cells[i] = blank;
          shadow_cursor = tcw_pkg::CELL_TOTAL - tcw_pkg::COLUMNS;
          r.scrolled = 1'b1;
        end else begin
          shadow_cursor = off + 1;
        end
      end
      tcw_pkg::MODE_CLEAR: begin
        for (i = 0; i < tcw_pkg::CELL_TOTAL; i++)
          shadow_cells[i] = blank;
        shadow_cursor = 0;
      end
      tcw_pkg::MODE_READ: begin
        r.cell_symbol = shadow_cells[off].symbol;
        r.cell_color = shadow_cells[off].color;
      end
      default: ;
    endcase
    r.cursor_pos = tcw_pkg::CURSOR_W'(shadow_cursor);
    return r;
  endfunction

  task automatic add_row(logic [1:0] mode, logic [7:0] sym, logic [7:0] color,
                         logic upos, logic [6:0] col, logic [4:0] row, bit known,
                         int cur, logic [7:0] rd_sym, logic [7:0] rd_color,
                         logic scr);
    dir_row_t d;
    d.c.mode = mode;
    d.c.symbol = sym;
    d.c.color = color;
    d.c.use_position = upos;
    d.c.col = col;
    d.c.row = row;
    d.known = known;
    d.want.cursor_pos = tcw_pkg::CURSOR_W'(cur);
    d.want.cell_symbol = rd_sym;
    d.want.cell_color = rd_color;
    d.want.scrolled = scr;
    dir_table.push_back(d);
  endtask

  task automatic send_cmd(tcw_pkg::cmd_t c, bit known, tcw_pkg::res_t typed);
    tcw_pkg::res_t predicted;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      @(negedge clk);
      start <= 1'b0;
    end
    @(negedge clk);
    start <= 1'b1;
    cmd <= c;
    do @(posedge clk); while (busy);
    predicted = console_apply(c);
    pending_results.push_back(known ? typed : predicted);
  endtask

  // drop start, then wait for every result and for the block to go idle
  task automatic wait_drained();
    @(negedge clk);
    start <= 1'b0;
    while (pending_results.size() != 0 || busy) @(posedge clk);
  endtask

  task automatic write_fill(logic [tcw_pkg::CFG_IDX_W-1:0] idx, logic [7:0] val);
    wait_drained();
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    if (idx == tcw_pkg::CFG_FILL_COLOR) fill_color_q = val;
    else fill_symbol_q = val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic run_random(int idle_pct, int count);
    tcw_pkg::cmd_t c;
    int            pick;
    send_idle_pct = idle_pct;
    repeat (count) begin
      c.mode = tcw_pkg::MODE_PUT;
      c.symbol = 8'($urandom_range(0, 255));
      c.color = 8'($urandom_range(0, 255));
      c.use_position = 1'($urandom_range(0, 1));
      c.col = 7'($urandom_range(0, 127));
      c.row = 5'($urandom_range(0, 31));
      pick = int'($urandom_range(0, 99));
      if (pick < 45) begin
        // text flowing from the cursor
        c.use_position = 1'b0;
        if ($urandom_range(0, 9) == 0) c.symbol = tcw_pkg::NEWLINE_CODE;
      end else if (pick < 60) begin
        c.use_position = 1'b1;
        c.col = 7'($urandom_range(0, tcw_pkg::COLUMNS - 1));
        c.row = ($urandom_range(0, 3) == 0) ? 5'(tcw_pkg::ROWS_COUNT - 1)
                                            : 5'($urandom_range(0, tcw_pkg::ROWS_COUNT - 1));
      end else if (pick < 65) begin
        c.use_position = 1'b1;
        if ($urandom_range(0, 1)) c.col = 7'($urandom_range(tcw_pkg::COLUMNS, 127));
        else c.row = 5'($urandom_range(tcw_pkg::ROWS_COUNT, 31));
      end else if (pick < 85) begin
        c.mode = tcw_pkg::MODE_READ;
        c.use_position = 1'b1;
        c.col = 7'($urandom_range(0, tcw_pkg::COLUMNS - 1));
        c.row = 5'($urandom_range(0, tcw_pkg::ROWS_COUNT - 1));
      end else if (pick < 90) begin
        c.mode = tcw_pkg::MODE_READ;
      end else if (pick < 93) begin
        c.use_position = 1'b1;
        c.col = 7'($urandom_range(0, tcw_pkg::COLUMNS - 1));
        c.row = 5'(tcw_pkg::ROWS_COUNT - 1);
        c.symbol = tcw_pkg::NEWLINE_CODE;
      end else if (pick < 96) begin
        c.mode = MODE_UNUSED;
      end else if (pick < 98) begin
        c.mode = tcw_pkg::MODE_CLEAR;
      end else begin
        c.use_position = 1'b1;
        c.col = 7'(tcw_pkg::COLUMNS - 1);
        c.row = 5'(tcw_pkg::ROWS_COUNT - 1);
      end
      send_cmd(c, 1'b0, '0);
    end
  endtask

  always @(posedge clk) begin
    tcw_pkg::res_t want;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX)
          $display("unexpected result: cursor %0d sym %02h color %02h scrolled %0b",
                   result.cursor_pos, result.cell_symbol, result.cell_color,
                   result.scrolled);
      end else begin
        want = pending_results.pop_front();
        if (result.cursor_pos !== want.cursor_pos ||
            result.cell_symbol !== want.cell_symbol ||
            result.cell_color !== want.cell_color ||
            result.scrolled !== want.scrolled) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_MAX)
            $display({"result mismatch: exp cursor %0d sym %02h color %02h scr %0b,",
                      " got cursor %0d sym %02h color %02h scr %0b"},
                     want.cursor_pos, want.cell_symbol, want.cell_color, want.scrolled,
                     result.cursor_pos, result.cell_symbol, result.cell_color,
                     result.scrolled);
        end
      end
    end
  end

  // watchdog: cycles without any transfer
  always @(posedge clk) begin
    if (rst || (start && !busy) || done || cfg_we) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    start = 1'b0;
    cmd = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    fill_color_q = tcw_pkg::FILL_COLOR_RST;
    fill_symbol_q = tcw_pkg::FILL_SYMBOL_RST;
    shadow_cursor = 0;
    foreach (shadow_cells[i]) shadow_cells[i] = '0;

    // mode, symbol, color, use_position, col, row, known, cursor, rd sym, rd color, scr
    add_row(MODE_UNUSED, 8'hff, 8'hff, 1'b1, 7'd127, 5'd31, 1'b1, 0, 8'h00, 8'h00, 1'b0);
    add_row(tcw_pkg::MODE_CLEAR, 8'h00, 8'h00, 1'b0, 7'd0, 5'd0, 1'b1, 0,
            8'h00, 8'h00, 1'b0);
    add_row(tcw_pkg::MODE_READ, 8'h00, 8'h00, 1'b1, 7'd0, 5'd0, 1'b1, 0,
            tcw_pkg::FILL_SYMBOL_RST, tcw_pkg::FILL_COLOR_RST, 1'b0);
    add_row(tcw_pkg::MODE_PUT, 8'h41, 8'h07, 1'b0, 7'd0, 5'd0, 1'b0, 0,
            8'h00, 8'h00, 1'b0);
    add_row(tcw_pkg::MODE_PUT, 8'h00, 8'h00, 1'b0, 7'd127, 5'd31, 1'b0, 0,
            8'h00, 8'h00, 1'b0);
    add_row(tcw_pkg::MODE_PUT, 8'hff, 8'hff, 1'b1, 7'd79, 5'd0, 1'b0, 0,
            8'h00, 8'h00, 1'b0);
    add_row(tcw_pkg::MODE_READ, 8'h00, 8'h00, 1'b1, 7'd79, 5'd0, 1'b0, 0,
            8'h00, 8'h00, 1'b0);
    add_row(tcw_pkg::MODE_PUT, tcw_pkg::NEWLINE_CODE, 8'h1e, 1'b0, 7'd0, 5'd0, 1'b0, 0,
            8'h00, 8'h00, 1'b0);
    add_row(tcw_pkg::MODE_PUT, tcw_pkg::NEWLINE_CODE, 8'h00, 1'b1, 7'd127, 5'd31, 1'b0, 0,
            8'h00, 8'h00, 1'b0);
    add_row(tcw_pkg::MODE_PUT, 8'h5a, 8'h2c, 1'b1, 7'(tcw_pkg::COLUMNS), 5'd0, 1'b0, 0,
            8'h00, 8'h00, 1'b0);
    add_row(tcw_pkg::MODE_PUT, 8'h61, 8'h4d, 1'b1, 7'd0, 5'(tcw_pkg::ROWS_COUNT), 1'b0, 0,
            8'h00, 8'h00, 1'b0);
    add_row(tcw_pkg::MODE_READ, 8'h00, 8'h00, 1'b1, 7'(tcw_pkg::COLUMNS), 5'd0, 1'b0, 0,
            8'h00, 8'h00, 1'b0);
    // last cell: scroll
    add_row(tcw_pkg::MODE_PUT, 8'h7e, 8'hc3, 1'b1, 7'd79, 5'd24, 1'b1,
            tcw_pkg::CELL_TOTAL - tcw_pkg::COLUMNS, 8'h00, 8'h00, 1'b1);
    add_row(tcw_pkg::MODE_READ, 8'h00, 8'h00, 1'b1, 7'd79, 5'd24, 1'b1,
            tcw_pkg::CELL_TOTAL - tcw_pkg::COLUMNS,
            tcw_pkg::FILL_SYMBOL_RST, tcw_pkg::FILL_COLOR_RST, 1'b0);
    add_row(tcw_pkg::MODE_READ, 8'h00, 8'h00, 1'b1, 7'd79, 5'd23, 1'b0, 0,
            8'h00, 8'h00, 1'b0);
    add_row(tcw_pkg::MODE_READ, 8'h00, 8'h00, 1'b1, 7'd79, 5'd0, 1'b0, 0,
            8'h00, 8'h00, 1'b0);
    // newline on the bottom row also scrolls
    add_row(tcw_pkg::MODE_PUT, tcw_pkg::NEWLINE_CODE, 8'h00, 1'b1, 7'd5, 5'd24, 1'b0, 0,
            8'h00, 8'h00, 1'b0);
    add_row(tcw_pkg::MODE_PUT, 8'h33, 8'h81, 1'b0, 7'd0, 5'd0, 1'b0, 0,
            8'h00, 8'h00, 1'b0);
    add_row(tcw_pkg::MODE_READ, 8'h00, 8'h00, 1'b0, 7'd0, 5'd0, 1'b0, 0,
            8'h00, 8'h00, 1'b0);
    add_row(tcw_pkg::MODE_READ, 8'h00, 8'h00, 1'b1, 7'd0, 5'd24, 1'b0, 0,
            8'h00, 8'h00, 1'b0);
    add_row(MODE_UNUSED, 8'h5a, 8'ha5, 1'b0, 7'd42, 5'd17, 1'b0, 0, 8'h00, 8'h00, 1'b0);
    add_row(tcw_pkg::MODE_READ, 8'h00, 8'h00, 1'b1, 7'd127, 5'd31, 1'b0, 0,
            8'h00, 8'h00, 1'b0);
    add_row(tcw_pkg::MODE_CLEAR, 8'hff, 8'hff, 1'b1, 7'd127, 5'd31, 1'b1, 0,
            8'h00, 8'h00, 1'b0);
    add_row(tcw_pkg::MODE_READ, 8'h00, 8'h00, 1'b1, 7'd79, 5'd24, 1'b1, 0,
            tcw_pkg::FILL_SYMBOL_RST, tcw_pkg::FILL_COLOR_RST, 1'b0);
    add_row(tcw_pkg::MODE_PUT, tcw_pkg::NEWLINE_CODE, 8'h00, 1'b0, 7'd0, 5'd0, 1'b0, 0,
            8'h00, 8'h00, 1'b0);

    repeat (7) @(negedge clk);
    rst <= 1'b0;

    send_idle_pct = 24;
    foreach (dir_table[i]) send_cmd(dir_table[i].c, dir_table[i].known, dir_table[i].want);

    write_fill(tcw_pkg::CFG_FILL_COLOR, 8'h00);
    write_fill(tcw_pkg::CFG_FILL_SYMBOL, 8'hff);
    run_random(24, RANDOM_PER_PHASE);

    write_fill(tcw_pkg::CFG_FILL_COLOR, 8'hff);
    write_fill(tcw_pkg::CFG_FILL_SYMBOL, 8'h00);
    run_random(60, RANDOM_PER_PHASE);

    write_fill(tcw_pkg::CFG_FILL_COLOR, 8'($urandom_range(0, 255)));
    write_fill(tcw_pkg::CFG_FILL_SYMBOL, 8'($urandom_range(0, 255)));
    run_random(0, RANDOM_PER_PHASE);

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    mismatch_count += pending_results.size();
    if (mismatch_count == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule

// ===== text_console_writer_top.f =====
+incdir+rtl/core
rtl/core/tcw_pkg.sv
rtl/core/tcw_cell_ram.sv
rtl/core/tcw_ctrl.sv
rtl/core/text_console_writer_top.sv
rtl/core/tcw_checker.sv
verif/text_console_writer_top_tb.sv
